FILE: hw/rtl/pva_pkg.sv
// Shared types and constants for the phase vocoder analysis block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package pva_pkg;

  localparam int BIN_W   = 10;
  localparam int DATA_W  = 32;
  localparam int FREQ_W  = 28;
  localparam int PHASE_W = 16;
  localparam int GUARD   = 8;
  // CORDIC datapath width: 32-bit input, guard bits, sign and gain growth
  localparam int CW      = 42;
  localparam int ANGLE_N = 24;

  localparam logic [63:0] KINF_Q32  = 64'd2608131496;
  localparam logic [34:0] MAG_LIMIT = 35'd3037000500;

  // configuration register indexes
  localparam logic CFG_FFT_SIZE = 1'b0;
  localparam logic CFG_OVERLAP  = 1'b1;

  localparam logic [3:0] FFT_LOG2_MIN = 4'd6;
  localparam logic [3:0] FFT_LOG2_MAX = 4'd11;

  // atan(2^-i) in Q32 turns
  localparam logic [31:0] ATAN_Q32 [ANGLE_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [BIN_W-1:0]         bin_number;
    logic signed [DATA_W-1:0] re_part;
    logic signed [DATA_W-1:0] im_part;
  } in_word_t;

  typedef struct packed {
    logic [BIN_W-1:0]         bin_out;
    logic [DATA_W-1:0]        magnitude;
    logic signed [FREQ_W-1:0] inst_freq;
  } out_word_t;

  // side data carried along the CORDIC pipeline
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             zero;
  } side_t;

  // phase store request from the pipeline
  typedef struct packed {
    logic               rd_en;
    logic [BIN_W-1:0]   rd_bin;
    logic               wr_en;
    logic [BIN_W-1:0]   wr_bin;
    logic [PHASE_W-1:0] wr_phase;
  } pmem_req_t;

endpackage

FILE: hw/rtl/phase_vocoder_analysis.sv
// Phase vocoder analysis: magnitude and instantaneous frequency per FFT bin.
// Throughput one word per cycle, except while the output stalls or the phase store is cleared.
// Pipeline: input stage, CORDIC_STEPS rotation stages, gain multiply, store read, write-back.
// Reset (rst, synchronous) clears control and config, then sweeps the phase store
// to zero with in_ready low. Depends on pva_pkg and submodules.
`timescale 1ns / 1ps
module phase_vocoder_analysis #(
  parameter int MAX_BINS     = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pva_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pva_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);
  import pva_pkg::*;

  localparam logic [63:0] KDIV   = (KINF_Q32 * 64'd2 / 64'd3) >> (2 * CORDIC_STEPS);
  localparam logic [31:0] K_COMP = 32'(KINF_Q32 + KDIV);

  logic [3:0] fft_size_log2;
  logic [1:0] overlap_log2;
  logic       en, mem_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fft_size_log2 <= 4'd11;
      overlap_log2  <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FFT_SIZE: fft_size_log2 <= cfg_data;
        CFG_OVERLAP:  overlap_log2  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the output register can take a word
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !mem_busy;

  // bin range check against half the frame and store depth
  logic [3:0]  fl;
  logic [10:0] half;
  logic        keep;
  always_comb begin
    fl = fft_size_log2;
    if (fl < FFT_LOG2_MIN) fl = FFT_LOG2_MIN;
    if (fl > FFT_LOG2_MAX) fl = FFT_LOG2_MAX;
    half = 11'd1 << (fl - 4'd1);
    keep = ({1'b0, in_data.bin_number} < half) && (32'(in_data.bin_number) < MAX_BINS);
  end

  // input stage: guard bits and half-turn prerotation
  logic signed [CW-1:0] gx, gy;
  logic                 s0_vld;
  logic signed [CW-1:0] s0_x, s0_y;
  logic [31:0]          s0_z;
  side_t                s0_side;

  assign gx = CW'(in_data.re_part) <<< GUARD;
  assign gy = CW'(in_data.im_part) <<< GUARD;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_valid && in_ready && keep;
    end
    if (en) begin
      s0_side.bin  <= in_data.bin_number;
      s0_side.zero <= (in_data.re_part == 0) && (in_data.im_part == 0);
      if (gx < 0) begin
        s0_x <= -gx;
        s0_y <= -gy;
        s0_z <= 32'h80000000;
      end else begin
        s0_x <= gx;
        s0_y <= gy;
        s0_z <= '0;
      end
    end
  end

  logic                 c_vld;
  logic signed [CW-1:0] c_x;
  logic [31:0]          c_z;
  side_t                c_side;

  pva_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s0_vld), .in_x(s0_x), .in_y(s0_y), .in_z(s0_z), .in_side(s0_side),
    .out_vld(c_vld), .out_x(c_x), .out_z(c_z), .out_side(c_side)
  );

  // gain stage: two partial products of the magnitude, phase rounding
  logic [CW-1:0]      ux;
  logic [31:0]        z_rnd;
  logic               p_vld;
  logic [57:0]        p_hi;
  logic [47:0]        p_lo;
  logic [PHASE_W-1:0] p_phase;
  logic [BIN_W-1:0]   p_bin;

  assign ux    = (c_x > 0) ? c_x : '0;
  assign z_rnd = c_z + 32'h8000;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= c_vld;
    end
    if (en) begin
      p_hi    <= 58'(ux[CW-1:16]) * 58'(K_COMP);
      p_lo    <= 48'(ux[15:0]) * 48'(K_COMP);
      p_phase <= c_side.zero ? '0 : z_rnd[31:16];
      p_bin   <= c_side.bin;
    end
  end

  // read stage: finish magnitude, issue store read
  logic [58:0]        msum;
  logic [34:0]        mag_full;
  logic               r_vld;
  logic [DATA_W-1:0]  r_mag;
  logic [PHASE_W-1:0] r_phase;
  logic [BIN_W-1:0]   r_bin;

  assign msum     = 59'(p_hi) + 59'(p_lo[47:16]);
  assign mag_full = msum[58:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (en) begin
      r_vld <= p_vld;
    end
    if (en) begin
      r_mag   <= (mag_full > MAG_LIMIT) ? MAG_LIMIT[31:0] : mag_full[31:0];
      r_phase <= p_phase;
      r_bin   <= p_bin;
    end
  end

  // write-back stage: phase difference against store, frequency
  pmem_req_t          req;
  logic [PHASE_W-1:0] prev_phase, expected, rem;
  logic [25:0]        bin_sh;
  logic signed [FREQ_W-1:0] freq;

  always_comb begin
    req.rd_en    = p_vld;
    req.rd_bin   = p_bin;
    req.wr_en    = r_vld;
    req.wr_bin   = r_bin;
    req.wr_phase = r_phase;
  end

  pva_phase_mem #(.MAX_BINS(MAX_BINS)) u_pmem (
    .clk(clk), .rst(rst), .en(en), .req(req),
    .prev_phase(prev_phase), .busy(mem_busy)
  );

  assign bin_sh   = {r_bin, 16'b0} >> overlap_log2;
  assign expected = bin_sh[15:0];
  assign rem      = r_phase - prev_phase - expected;
  assign freq     = (FREQ_W'(signed'(rem)) <<< overlap_log2)
                  + FREQ_W'(signed'({2'b00, r_bin, 16'b0}));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r_vld;
    end
    if (en) begin
      out_data.bin_out   <= r_bin;
      out_data.magnitude <= r_mag;
      out_data.inst_freq <= freq;
    end
  end

endmodule

FILE: hw/rtl/pva_cordic.sv
// Pipelined vectoring CORDIC, one iteration per register stage.
// Depends on pva_pkg for widths, angle table and side-data type.
`timescale 1ns / 1ps
module pva_cordic #(
  parameter int STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [pva_pkg::CW-1:0]  in_x,
  input  logic signed [pva_pkg::CW-1:0]  in_y,
  input  logic [31:0]                    in_z,
  input  pva_pkg::side_t                 in_side,
  output logic                           out_vld,
  output logic signed [pva_pkg::CW-1:0]  out_x,
  output logic [31:0]                    out_z,
  output pva_pkg::side_t                 out_side
);
  import pva_pkg::*;

  logic                 vld  [STEPS+1];
  logic signed [CW-1:0] xs   [STEPS+1];
  logic signed [CW-1:0] ys   [STEPS+1];
  logic [31:0]          zs   [STEPS+1];
  side_t                side [STEPS+1];

  assign vld[0]  = in_vld;
  assign xs[0]   = in_x;
  assign ys[0]   = in_y;
  assign zs[0]   = in_z;
  assign side[0] = in_side;

  // one micro-rotation per stage, shift amount fixed by stage
  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        side[i+1] <= side[i];
        if (ys[i] < 0) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - ATAN_Q32[i];
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + ATAN_Q32[i];
        end
      end
    end
  end

  assign out_vld  = vld[STEPS];
  assign out_x    = xs[STEPS];
  assign out_z    = zs[STEPS];
  assign out_side = side[STEPS];

endmodule

FILE: hw/rtl/pva_phase_mem.sv
// Per-bin previous-phase store: registered read, write-back, forwarding, clear sweep.
// Depends on pva_pkg for the request type and widths.
`timescale 1ns / 1ps
module pva_phase_mem #(
  parameter int MAX_BINS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  pva_pkg::pmem_req_t             req,
  output logic [pva_pkg::PHASE_W-1:0]    prev_phase,
  output logic                           busy
);
  import pva_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int EXT_W = (IDX_W > BIN_W) ? IDX_W : BIN_W;
  localparam int CNT_W = IDX_W + 1;

  logic [PHASE_W-1:0] mem [MAX_BINS];
  logic [EXT_W-1:0]   rd_ext, wr_ext;
  logic [IDX_W-1:0]   rd_idx, wr_idx;
  logic [CNT_W-1:0]   clr_cnt;
  logic [PHASE_W-1:0] rd_data, fwd_data;
  logic               fwd;

  assign rd_ext = EXT_W'(req.rd_bin);
  assign wr_ext = EXT_W'(req.wr_bin);
  assign rd_idx = rd_ext[IDX_W-1:0];
  assign wr_idx = wr_ext[IDX_W-1:0];
  assign busy   = (clr_cnt != CNT_W'(MAX_BINS));

  // clear sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // memory: write-back or clear, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[IDX_W-1:0]] <= '0;
    end else if (en && req.wr_en) begin
      mem[wr_idx] <= req.wr_phase;
    end
    if (en && req.rd_en) begin
      rd_data  <= mem[rd_idx];
      fwd      <= req.wr_en && (wr_idx == rd_idx);
      fwd_data <= req.wr_phase;
    end
  end

  // a write in the cycle of the read wins over the stale array data
  assign prev_phase = fwd ? fwd_data : rd_data;

endmodule

FILE: sim/phase_vocoder_analysis_tb.sv
// Testbench for phase_vocoder_analysis: random and directed FFT bins against a predictor.
// Depends on pva_pkg and the phase_vocoder_analysis RTL.
`timescale 1ns / 1ps

// Holds expected words and compares results as they arrive.
class freq_scoreboard;
  pva_pkg::out_word_t pending_q[$];
  int mismatches;
  int orphans;

  function new();
    mismatches = 0;
    orphans = 0;
  endfunction

  function void note_word(pva_pkg::out_word_t w);
    pending_q.push_back(w);
  endfunction

  function void check_word(pva_pkg::out_word_t got);
    pva_pkg::out_word_t want;
    if (pending_q.size() == 0) begin
      orphans++;
      if (mismatches + orphans <= 10)
        $display("unexpected result word bin=%0d mag=%0d freq=%0d",
                 got.bin_out, got.magnitude, got.inst_freq);
      return;
    end
    want = pending_q.pop_front();
    if (got.bin_out !== want.bin_out || got.magnitude !== want.magnitude ||
        got.inst_freq !== want.inst_freq) begin
      mismatches++;
      if (mismatches + orphans <= 10)
        $display("mismatch: exp bin=%0d mag=%0d freq=%0d  got bin=%0d mag=%0d freq=%0d",
                 want.bin_out, want.magnitude, want.inst_freq,
                 got.bin_out, got.magnitude, got.inst_freq);
    end
  endfunction
endclass

module phase_vocoder_analysis_tb;
  import pva_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [3:0] cfg_data;

  freq_scoreboard sb;
  logic [3:0] size_reg;
  logic [1:0] ovl_reg;
  logic [15:0] last_phase [1024];
  bit hold_off;
  int sent_in_burst;

  phase_vocoder_analysis dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor shift on a wide signed value
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC vectoring: phase in Q16 turns and gain-corrected magnitude
  function automatic void vector_polar(longint re, longint im,
                                       output logic [15:0] ph,
                                       output logic [31:0] mag);
    longint x, y, dx, dy;
    logic [31:0] z;
    logic [63:0] k, ux, prod;
    x = re <<< 8;
    y = im <<< 8;
    z = 32'd0;
    if (re == 0 && im == 0) begin
      ph = 16'd0;
      mag = 32'd0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q32[i];
      end
    end
    ph = 16'((z + 32'h8000) >> 16);
    k = KINF_Q32 + ((KINF_Q32 * 2 / 3) >> 32);
    ux = (x > 0) ? 64'(x) : 64'd0;
    prod = (((ux >> 16) * k + (((ux & 64'hFFFF) * k) >> 16)) >> 16) >> 8;
    if (prod > 64'(MAG_LIMIT)) prod = 64'(MAG_LIMIT);
    mag = prod[31:0];
  endfunction

  // predict one accepted word; Nyquist and above yield nothing
  task automatic predict_bin(in_word_t w);
    int fl;
    logic [15:0] ph, adv, rem;
    logic [31:0] mag;
    int srem, freq;
    out_word_t r;
    fl = size_reg;
    if (fl < 6) fl = 6;
    if (fl > 11) fl = 11;
    if (w.bin_number >= (1 << (fl - 1))) return;
    vector_polar(longint'(w.re_part), longint'(w.im_part), ph, mag);
    adv = 16'(32'(w.bin_number) << (16 - ovl_reg));
    rem = ph - last_phase[w.bin_number] - adv;
    last_phase[w.bin_number] = ph;
    srem = rem[15] ? int'(rem) - 65536 : int'(rem);
    freq = srem * (1 << ovl_reg) + (int'(w.bin_number) << 16);
    r.bin_out = w.bin_number;
    r.magnitude = mag;
    r.inst_freq = freq[27:0];
    sb.note_word(r);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FFT_SIZE) size_reg = val;
    else ovl_reg = val[1:0];
  endtask

  // offer one word with bursty gaps; hold valid until accepted
  task automatic send_bin(logic [9:0] b, logic [31:0] re, logic [31:0] im, bit gaps);
    if (gaps && sent_in_burst <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      sent_in_burst = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data <= '{bin_number: b, re_part: re, im_part: im};
    do @(posedge clk); while (!in_ready);
    predict_bin(in_data);
    sent_in_burst--;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random bin value with mixed magnitudes
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom & 32'h8000FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_word(out_data);

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [3:0] sizes [6];
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FFT_SIZE;
    cfg_data = 4'd0;
    hold_off = 1'b0;
    sent_in_burst = 0;
    size_reg = 4'd11;
    ovl_reg = 2'd2;
    foreach (last_phase[i]) last_phase[i] = 16'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero input, axes, Nyquist, half-turn cases
    send_bin(10'd0, 32'd0, 32'd0, 0);
    send_bin(10'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_bin(10'd2, 32'h80000000, 32'h80000000, 0);
    send_bin(10'd3, 32'h80000000, 32'd0, 0);
    send_bin(10'd4, 32'd0, 32'h80000000, 0);
    send_bin(10'd5, 32'd0, 32'h7FFFFFFF, 0);
    send_bin(10'd511, 32'h7FFFFFFF, 32'h80000000, 0);
    send_bin(10'd512, 32'd100, 32'd100, 0);
    send_bin(10'd1023, 32'hFFFFFFFF, 32'd1, 0);
    send_bin(10'd3, 32'h80000000, 32'd0, 0);
    send_bin(10'd3, 32'h7FFFFFFF, 32'd0, 0);
    send_bin(10'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    drain();
    write_reg(CFG_OVERLAP, 4'd0);
    write_reg(CFG_FFT_SIZE, 4'd15);
    send_bin(10'd7, 32'd5, 32'h7FFFFFFF, 0);
    send_bin(10'd7, 32'd5, 32'h80000000, 0);
    send_bin(10'd1023, 32'd1, 32'd1, 0);
    drain();
    write_reg(CFG_FFT_SIZE, 4'd0);
    write_reg(CFG_OVERLAP, 4'd3);
    send_bin(10'd31, 32'h12345678, 32'h9ABCDEF0, 0);
    send_bin(10'd32, 32'd1, 32'd1, 0);
    send_bin(10'd0, 32'd1, 32'd0, 0);
    drain();

    // random phases over several register settings
    sizes = '{4'd6, 4'd11, 4'd8, 4'd3, 4'd13, 4'd10};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_FFT_SIZE, sizes[ph]);
      write_reg(CFG_OVERLAP, 4'($urandom_range(0, 3)));
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 255; n++) begin
        int fl;
        logic [9:0] b;
        fl = sizes[ph] < 6 ? 6 : (sizes[ph] > 11 ? 11 : sizes[ph]);
        if ($urandom_range(0, 15) == 0) b = 10'($urandom);
        else b = 10'($urandom_range(0, (1 << (fl - 1)) - 1));
        send_bin(b, rand_part(), rand_part(), ph != 2);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/pva_pkg.sv
hw/rtl/pva_cordic.sv
hw/rtl/pva_phase_mem.sv
hw/rtl/phase_vocoder_analysis.sv
sim/phase_vocoder_analysis_tb.sv
